@@ hdl/bfd_pkg.sv @@
package bfd_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_SS         = 4;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int CFG_DW  = 11;
    localparam int CFG_IW  = 2;
    localparam int SSR_W   = 3;

    localparam logic [CFG_DW-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_DW-1:0] HEIGHT_RST = 11'd480;
    localparam logic [SSR_W-1:0]  SS_RST     = 3'd1;

    // widths of the effective factor, sums and the divide by S*S
    localparam int SS_W   = $clog2(MAX_SS + 1);
    localparam int SUM_W  = $clog2(MAX_SS * 255 + 1);
    localparam int TOT_W  = $clog2(MAX_SS * MAX_SS * 255 + 1);
    localparam int N_W    = $clog2(MAX_SS * MAX_SS + 1);
    localparam int X_W    = $clog2(MAX_SS * MAX_SS * 255 + MAX_SS * MAX_SS / 2 + 1);
    localparam int RCP_K  = X_W + N_W;
    localparam int R_W    = RCP_K + 1;
    localparam int P_W    = X_W + R_W;
    localparam int RIW    = (MAX_SS > 1) ? $clog2(MAX_SS) : 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = 2;

    typedef enum logic [CFG_IW-1:0] {
        CFG_OUT_WIDTH   = 2'd0,
        CFG_OUT_HEIGHT  = 2'd1,
        CFG_SUPERSAMPLE = 2'd2
    } cfg_idx_t;

    // one finished horizontal run of a block row, handed to the back end
    typedef struct packed {
        logic [3:0][SUM_W-1:0] sums;
        logic [COORD_W-1:0]    col;
        logic [COORD_W-1:0]    row;
        logic                  first;
        logic                  emit;
        logic                  last;
    } entry_t;

endpackage

@@ hdl/bfd_pix_if.sv @@
interface bfd_pix_if;
    import bfd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

@@ hdl/bfd_res_if.sv @@
interface bfd_res_if;
    import bfd_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   red_out;
    logic [PIX_W-1:0]   green_out;
    logic [PIX_W-1:0]   blue_out;
    logic [PIX_W-1:0]   alpha_out;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic               frame_done;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output pixel_col, output pixel_row,
                    output frame_done, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, input pixel_col, input pixel_row,
                  input frame_done, output ready);
endinterface

@@ hdl/bfd_cfg_if.sv @@
interface bfd_cfg_if;
    import bfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/bfd_ram.sv @@
module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ hdl/bfd_front.sv @@
module bfd_front #(
    parameter int MAX_WIDTH  = bfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bfd_pkg::MAX_HEIGHT_DEF,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bfd_pix_if.sink                   pix,
    bfd_cfg_if.sink                   cfg,
    output logic                      push,
    input  logic                      full,
    output bfd_pkg::entry_t           push_entry,
    output logic [AW-1:0]             push_addr,
    output logic [bfd_pkg::SS_W-1:0]  ss_eff
);
    import bfd_pkg::*;

    localparam int CEW = $clog2(MAX_WIDTH + 1);
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HEW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_DW-1:0] width_reg;
    logic [CFG_DW-1:0] height_reg;
    logic [SSR_W-1:0]  ss_reg;

    logic [3:0][SUM_W-1:0] block_sum_reg;
    logic [3:0][SUM_W-1:0] block_sum_next;
    logic [SS_W-1:0]       sub_col_reg;
    logic [SS_W-1:0]       sub_row_reg;
    logic [AW-1:0]         col_count_reg;
    logic [RW-1:0]         row_count_reg;

    logic [CEW-1:0] w_eff;
    logic [HEW-1:0] h_eff;
    logic           accept;
    logic           blk_end;
    logic           row_blk_end;
    logic           col_end;
    logic           row_end;
    logic           restart;

    // out-of-range register values act as the nearest legal value
    always_comb
    begin
        if (width_reg == '0)
            w_eff = CEW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = CEW'(MAX_WIDTH);
        else
            w_eff = CEW'(width_reg);

        if (height_reg == '0)
            h_eff = HEW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HEW'(MAX_HEIGHT);
        else
            h_eff = HEW'(height_reg);

        if (ss_reg == '0)
            ss_eff = SS_W'(1);
        else if (32'(ss_reg) > MAX_SS)
            ss_eff = SS_W'(MAX_SS);
        else
            ss_eff = SS_W'(ss_reg);
    end

    assign pix.ready = !full;
    assign cfg.ready = 1'b1;
    assign accept    = pix.valid && pix.ready;

    assign block_sum_next[0] = block_sum_reg[0] + SUM_W'(pix.red_in);
    assign block_sum_next[1] = block_sum_reg[1] + SUM_W'(pix.green_in);
    assign block_sum_next[2] = block_sum_reg[2] + SUM_W'(pix.blue_in);
    assign block_sum_next[3] = block_sum_reg[3] + SUM_W'(pix.alpha_in);

    assign blk_end     = (sub_col_reg + SS_W'(1)) >= ss_eff;
    assign row_blk_end = (sub_row_reg + SS_W'(1)) >= ss_eff;
    assign col_end     = (CEW'(col_count_reg) + CEW'(1)) >= w_eff;
    assign row_end     = (HEW'(row_count_reg) + HEW'(1)) >= h_eff;

    assign push             = accept && blk_end;
    assign push_addr        = col_count_reg;
    assign push_entry.sums  = block_sum_next;
    assign push_entry.col   = COORD_W'(32'(col_count_reg));
    assign push_entry.row   = COORD_W'(32'(h_eff) - 32'd1 - 32'(row_count_reg));
    assign push_entry.first = (sub_row_reg == '0);
    assign push_entry.emit  = row_blk_end;
    assign push_entry.last  = col_end && row_end;

    always_comb
    begin
        case (cfg_idx_t'(cfg.index))
            CFG_OUT_WIDTH,
            CFG_OUT_HEIGHT,
            CFG_SUPERSAMPLE: restart = cfg.valid;
            default:         restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            ss_reg        <= SS_RST;
            block_sum_reg <= '0;
            sub_col_reg   <= '0;
            sub_row_reg   <= '0;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (restart)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_OUT_WIDTH:   width_reg  <= cfg.data;
                CFG_OUT_HEIGHT:  height_reg <= cfg.data;
                CFG_SUPERSAMPLE: ss_reg     <= cfg.data[SSR_W-1:0];
                default:         ;
            endcase
            block_sum_reg <= '0;
            sub_col_reg   <= '0;
            sub_row_reg   <= '0;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            if (!blk_end)
            begin
                block_sum_reg <= block_sum_next;
                sub_col_reg   <= sub_col_reg + SS_W'(1);
            end
            else
            begin
                block_sum_reg <= '0;
                sub_col_reg   <= '0;
                if (!col_end)
                begin
                    col_count_reg <= col_count_reg + AW'(1);
                end
                else
                begin
                    col_count_reg <= '0;
                    if (!row_blk_end)
                    begin
                        sub_row_reg <= sub_row_reg + SS_W'(1);
                    end
                    else
                    begin
                        sub_row_reg <= '0;
                        row_count_reg <= row_end ? '0 : row_count_reg + RW'(1);
                    end
                end
            end
        end
    end
endmodule

@@ hdl/bfd_fifo.sv @@
module bfd_fifo #(
    parameter int AW = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bfd_pkg::entry_t push_entry,
    input  logic [AW-1:0]   push_addr,
    output logic            full,
    input  logic            pop,
    output bfd_pkg::entry_t pop_entry,
    output logic [AW-1:0]   pop_addr,
    output logic            empty
);
    import bfd_pkg::*;

    entry_t          ent_q  [Q_DEPTH];
    logic [AW-1:0]   addr_q [Q_DEPTH];
    logic [Q_PW-1:0] wr_ptr_reg;
    logic [Q_PW-1:0] rd_ptr_reg;
    logic [Q_PW:0]   count_reg;

    assign full      = (count_reg == (Q_PW + 1)'(Q_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = ent_q[rd_ptr_reg];
    assign pop_addr  = addr_q[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_q[wr_ptr_reg]  <= push_entry;
            addr_q[wr_ptr_reg] <= push_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PW'(1);
            if (push && !pop)
                count_reg <= count_reg + (Q_PW + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (Q_PW + 1)'(1);
        end
    end
endmodule

@@ hdl/bfd_back.sv @@
module bfd_back #(
    parameter int MAX_WIDTH = bfd_pkg::MAX_WIDTH_DEF,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    output logic                     pop,
    input  logic                     empty,
    input  bfd_pkg::entry_t          pop_entry,
    input  logic [AW-1:0]            pop_addr,
    input  logic [bfd_pkg::SS_W-1:0] ss_eff,
    bfd_res_if.source                res
);
    import bfd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_WB   = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    entry_t                ent_reg;
    logic [AW-1:0]         addr_reg;
    logic [3:0][X_W-1:0]   x_reg;
    logic [1:0]            chan_reg;
    logic [P_W-1:0]        prod_reg;
    logic [3:0][PIX_W-1:0] quot_reg;
    logic                  out_valid_reg;
    logic [3:0][PIX_W-1:0] out_pix_reg;
    logic [COORD_W-1:0]    out_col_reg;
    logic [COORD_W-1:0]    out_row_reg;
    logic                  out_last_reg;

    logic [R_W-1:0]        rcp_tab [MAX_SS];
    logic [RIW-1:0]        rcp_idx;
    logic [R_W-1:0]        rcp;
    logic [N_W-1:0]        n_val;
    logic [N_W-1:0]        n_half;
    logic [4*TOT_W-1:0]    ram_rd;
    logic [4*TOT_W-1:0]    ram_wr;
    logic [3:0][TOT_W-1:0] tot;
    logic                  ram_we;
    logic                  out_free;

    // reciprocal of S*S, scaled by 2**RCP_K and rounded up; exact for every
    // dividend the block can see
    for (genvar g = 0; g < MAX_SS; g++)
    begin : g_rcp
        localparam int unsigned NN = (g + 1) * (g + 1);
        localparam int unsigned RV = ((1 << RCP_K) + NN - 1) / NN;
        assign rcp_tab[g] = R_W'(RV);
    end

    assign rcp_idx = RIW'(ss_eff - SS_W'(1));
    assign rcp     = rcp_tab[rcp_idx];
    assign n_val   = N_W'(ss_eff) * N_W'(ss_eff);
    assign n_half  = n_val >> 1;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            tot[c] = TOT_W'(ent_reg.sums[c])
                   + (ent_reg.first ? '0 : ram_rd[c*TOT_W +: TOT_W]);
        end
    end

    assign ram_wr   = tot;
    assign ram_we   = (state_reg == ST_SUM) && !ent_reg.emit;
    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign out_free = !out_valid_reg || res.ready;

    bfd_ram #(
        .WIDTH (4 * TOT_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (addr_reg),
        .wr_data (ram_wr),
        .rd_en   (pop),
        .rd_addr (pop_addr),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!empty) state_next = ST_SUM;
            ST_SUM:  state_next = ent_reg.emit ? ST_MUL : ST_IDLE;
            ST_MUL:  if (chan_reg == 2'd3) state_next = ST_WB;
            ST_WB:   state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg  <= pop_entry;
            addr_reg <= pop_addr;
        end
        if (state_reg == ST_SUM)
        begin
            for (int c = 0; c < 4; c++)
            begin
                x_reg[c] <= X_W'(tot[c]) + X_W'(n_half);
            end
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= P_W'(x_reg[chan_reg]) * P_W'(rcp);
            // product of the previous channel is ready now
            if (chan_reg != 2'd0)
                quot_reg[chan_reg - 2'd1] <= prod_reg[RCP_K +: PIX_W];
        end
        if (state_reg == ST_WB)
        begin
            quot_reg[3] <= prod_reg[RCP_K +: PIX_W];
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_pix_reg  <= quot_reg;
            out_col_reg  <= ent_reg.col;
            out_row_reg  <= ent_reg.row;
            out_last_reg <= ent_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL)
                chan_reg <= chan_reg + 2'd1;
            else
                chan_reg <= '0;
            if ((state_reg == ST_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.red_out    = out_pix_reg[0];
    assign res.green_out  = out_pix_reg[1];
    assign res.blue_out   = out_pix_reg[2];
    assign res.alpha_out  = out_pix_reg[3];
    assign res.pixel_col  = out_col_reg;
    assign res.pixel_row  = out_row_reg;
    assign res.frame_done = out_last_reg;
endmodule

@@ hdl/box_filter_downsampler.sv @@
// Box-filter downsampler for RGBA8 pixels, supersampled frame in, raster
// order, bottom row first.
// pix: source pixels, valid/ready. res: averaged output pixels with column,
// top-down row and a frame_done flag on the last pixel of the frame.
// cfg: register writes (0 out_width, 1 out_height, 2 supersample); ready is
// always high and any known write restarts the frame. Write only while idle.
// The front end takes one pixel per cycle while its 4-deep item queue has
// room. The back end handles one item at a time: an item that only updates
// the column store takes a column store read and the sum; one that yields
// an output pixel goes on through one shared multiplier doing the rounded
// divide by S*S for the four channels in turn, then the output register.
// With S = 1 every pixel is an output. At larger S the block rows that only
// update the column store run at one pixel per cycle while the queue has
// room, and the last block row is paced by the back end's divide.
// A stalled receiver holds the output register; the back end then waits
// and the queue fills, after which pix.ready drops.
// Reset loads 640 x 480 with S = 1 and clears all counters and sums; the
// column store is not cleared, as the first block row never reads it.
module box_filter_downsampler #(
    parameter int MAX_WIDTH  = bfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bfd_pkg::MAX_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bfd_pix_if.sink    pix,
    bfd_res_if.source  res,
    bfd_cfg_if.sink    cfg
);
    import bfd_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic            push;
    logic            full;
    entry_t          push_entry;
    logic [AW-1:0]   push_addr;
    logic            pop;
    logic            empty;
    entry_t          pop_entry;
    logic [AW-1:0]   pop_addr;
    logic [SS_W-1:0] ss_eff;

    bfd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .cfg        (cfg),
        .push       (push),
        .full       (full),
        .push_entry (push_entry),
        .push_addr  (push_addr),
        .ss_eff     (ss_eff)
    );

    bfd_fifo #(
        .AW (AW)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_addr  (push_addr),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .pop_addr   (pop_addr),
        .empty      (empty)
    );

    bfd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .empty     (empty),
        .pop_entry (pop_entry),
        .pop_addr  (pop_addr),
        .ss_eff    (ss_eff),
        .res       (res)
    );
endmodule

@@ verif/box_filter_downsampler_tb.sv @@
module box_filter_downsampler_tb;
    import bfd_pkg::*;

    localparam logic [CFG_IW-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_ITEMS    = 100;
    localparam int WIDE_ITEMS      = 1030;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } src_pix_t;

    typedef struct packed {
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
        logic [PIX_W-1:0]   alpha;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               done;
    } out_pix_t;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE} sink_mode_t;

    // box averaging predictor plus the queue of output pixels it expects
    class box_avg_model;
        logic [CFG_DW-1:0] width_reg;
        logic [CFG_DW-1:0] height_reg;
        logic [SSR_W-1:0]  ss_reg;
        int unsigned       col_sum [MAX_WIDTH_DEF][4];
        int unsigned       blk_acc [4];
        int unsigned       sub_x;
        int unsigned       sub_y;
        int unsigned       out_x;
        int unsigned       out_y;
        out_pix_t          expected_pixels [$];
        int                errors;

        function new();
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            ss_reg     = SS_RST;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            for (int c = 0; c < 4; c++)
                blk_acc[c] = 0;
            sub_x = 0;
            sub_y = 0;
            out_x = 0;
            out_y = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < 1)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned eff_w();
            return clamp_dim(width_reg, MAX_WIDTH_DEF);
        endfunction

        function int unsigned eff_h();
            return clamp_dim(height_reg, MAX_HEIGHT_DEF);
        endfunction

        function int unsigned eff_s();
            return clamp_dim(ss_reg, MAX_SS);
        endfunction

        function int unsigned frame_pixels();
            return eff_w() * eff_h() * eff_s() * eff_s();
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_OUT_WIDTH:   width_reg = data;
                CFG_OUT_HEIGHT:  height_reg = data;
                CFG_SUPERSAMPLE: ss_reg = data[SSR_W-1:0];
                default:         return;
            endcase
            restart();
        endfunction

        function void note_pixel(src_pix_t p);
            int unsigned w;
            int unsigned h;
            int unsigned s;
            int unsigned n;
            int unsigned ch [4];
            int unsigned total [4];
            int unsigned avg [4];
            out_pix_t    r;
            w = eff_w();
            h = eff_h();
            s = eff_s();
            n = s * s;
            ch[0] = p.red;
            ch[1] = p.green;
            ch[2] = p.blue;
            ch[3] = p.alpha;
            for (int c = 0; c < 4; c++)
                blk_acc[c] += ch[c];
            if (sub_x + 1 < s) begin
                sub_x++;
                return;
            end
            // horizontal run done: fold in the rows above from the line store
            for (int c = 0; c < 4; c++) begin
                total[c]   = blk_acc[c] + ((sub_y == 0) ? 0 : col_sum[out_x][c]);
                blk_acc[c] = 0;
            end
            sub_x = 0;
            if (sub_y + 1 >= s) begin
                for (int c = 0; c < 4; c++)
                    avg[c] = (total[c] + n / 2) / n;
                r.red   = PIX_W'(avg[0]);
                r.green = PIX_W'(avg[1]);
                r.blue  = PIX_W'(avg[2]);
                r.alpha = PIX_W'(avg[3]);
                r.col   = COORD_W'(out_x);
                r.row   = COORD_W'(h - 1 - out_y);
                r.done  = (out_x + 1 >= w) && (out_y + 1 >= h);
                expected_pixels.push_back(r);
            end else begin
                for (int c = 0; c < 4; c++)
                    col_sum[out_x][c] = total[c];
            end
            if (out_x + 1 < w) begin
                out_x++;
            end else begin
                out_x = 0;
                if (sub_y + 1 < s) begin
                    sub_y++;
                end else begin
                    sub_y = 0;
                    out_y = (out_y + 1 < h) ? out_y + 1 : 0;
                end
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(out_pix_t got);
            out_pix_t want;
            if (expected_pixels.size() == 0) begin
                $error("output pixel with none expected: col %0d row %0d", got.col, got.row);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("red_out", want.red, got.red);
            compare_field("green_out", want.green, got.green);
            compare_field("blue_out", want.blue, got.blue);
            compare_field("alpha_out", want.alpha, got.alpha);
            compare_field("pixel_col", want.col, got.col);
            compare_field("pixel_row", want.row, got.row);
            compare_field("frame_done", want.done, got.done);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bfd_pix_if pix_bus ();
    bfd_res_if res_bus ();
    bfd_cfg_if cfg_bus ();

    box_filter_downsampler i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    box_avg_model model = new();
    int unsigned  burst_left = 0;
    bit           hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("box_filter_downsampler_tb: errors");
        $finish;
    end

    function automatic src_pix_t mk_pixel(int unsigned r, int unsigned g, int unsigned b,
                                          int unsigned a);
        src_pix_t p;
        p.red   = PIX_W'(r);
        p.green = PIX_W'(g);
        p.blue  = PIX_W'(b);
        p.alpha = PIX_W'(a);
        return p;
    endfunction

    // mostly uniform channels, now and then pinned to the ends of the range
    function automatic logic [PIX_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic src_pix_t rand_pixel();
        return mk_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    endfunction

    task automatic send_pixel(input src_pix_t p);
        pix_bus.valid    <= 1'b1;
        pix_bus.red_in   <= p.red;
        pix_bus.green_in <= p.green;
        pix_bus.blue_in  <= p.blue;
        pix_bus.alpha_in <= p.alpha;
        do
            @(posedge clk);
        while (!pix_bus.ready);
        model.note_pixel(p);
    endtask

    task automatic offer_pixel(input src_pix_t p);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                pix_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        send_pixel(p);
    endtask

    // wait for every expected pixel, then let the back end finish column updates
    task automatic settle();
        pix_bus.valid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        model.write_reg(idx, data);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // output side: own stall pattern, plus one long hold-off on request
    initial
    begin : result_sink
        out_pix_t    seen;
        sink_mode_t  mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode          = SINK_OPEN;
        mode_left     = 0;
        hold_left     = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready) begin
                seen.red   = res_bus.red_out;
                seen.green = res_bus.green_out;
                seen.blue  = res_bus.blue_out;
                seen.alpha = res_bus.alpha_out;
                seen.col   = res_bus.pixel_col;
                seen.row   = res_bus.pixel_row;
                seen.done  = res_bus.frame_done;
                model.check_pixel(seen);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN: res_bus.ready <= 1'b1;
                    SINK_COIN: res_bus.ready <= $urandom_range(0, 1);
                    default:   res_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int unsigned random_items;
        int unsigned frame_px;
        int unsigned count;
        rst_n            <= 1'b0;
        pix_bus.valid    <= 1'b0;
        pix_bus.red_in   <= '0;
        pix_bus.green_in <= '0;
        pix_bus.blue_in  <= '0;
        pix_bus.alpha_in <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= CFG_OUT_WIDTH;
        cfg_bus.data     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, S = 1: straight pass-through
        offer_pixel(mk_pixel(0, 0, 0, 0));
        offer_pixel(mk_pixel(255, 255, 255, 255));

        // single 2x2 block, sums landing on and below the half
        settle();
        set_reg(CFG_OUT_WIDTH, 11'd1);
        set_reg(CFG_OUT_HEIGHT, 11'd1);
        set_reg(CFG_SUPERSAMPLE, 11'd2);
        offer_pixel(mk_pixel(0, 1, 255, 1));
        offer_pixel(mk_pixel(0, 0, 255, 1));
        offer_pixel(mk_pixel(0, 0, 255, 0));
        offer_pixel(mk_pixel(2, 0, 255, 0));

        // unknown index mid-frame must leave the frame running
        offer_pixel(rand_pixel());
        offer_pixel(rand_pixel());
        settle();
        set_reg(CFG_SPARE_IDX, 11'h7ff);
        offer_pixel(rand_pixel());
        offer_pixel(rand_pixel());

        // out-of-range registers: width 0, height above max, S above max
        settle();
        set_reg(CFG_OUT_WIDTH, 11'd0);
        set_reg(CFG_OUT_HEIGHT, 11'h7ff);
        set_reg(CFG_SUPERSAMPLE, 11'd7);
        repeat (16) offer_pixel(rand_pixel());
        settle();
        set_reg(CFG_SUPERSAMPLE, 11'd0);
        set_reg(CFG_OUT_WIDTH, 11'd2);
        set_reg(CFG_OUT_HEIGHT, 11'd1);
        repeat (2) offer_pixel(rand_pixel());

        // widest row at S = 1 with the output held off for a while
        settle();
        set_reg(CFG_OUT_WIDTH, 11'h7ff);
        set_reg(CFG_OUT_HEIGHT, 11'd1024);
        set_reg(CFG_SUPERSAMPLE, 11'd1);
        hold_req = 1'b1;
        repeat (WIDE_ITEMS) offer_pixel(rand_pixel());

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 15))
                    0:       set_reg(CFG_OUT_WIDTH, 11'd0);
                    1:       set_reg(CFG_OUT_WIDTH, CFG_DW'($urandom_range(7, 24)));
                    default: set_reg(CFG_OUT_WIDTH, CFG_DW'($urandom_range(1, 6)));
                endcase
            end
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 15) == 0)
                    set_reg(CFG_OUT_HEIGHT, 11'd0);
                else
                    set_reg(CFG_OUT_HEIGHT, CFG_DW'($urandom_range(1, 4)));
            end
            if ($urandom_range(0, 3) != 0)
                set_reg(CFG_SUPERSAMPLE, CFG_DW'($urandom_range(0, 7)));
            if ($urandom_range(0, 7) == 0)
                set_reg(CFG_SPARE_IDX, CFG_DW'($urandom));
            if (model.eff_w() > 24) begin
                // wide row left over from before: shrink it
                set_reg(CFG_OUT_WIDTH, CFG_DW'($urandom_range(1, 6)));
            end
            frame_px = model.frame_pixels();
            count    = frame_px * ((frame_px > 200) ? 1 : $urandom_range(1, 3));
            // now and then a broken frame, cut short by the next write
            if ($urandom_range(0, 3) == 0)
                count += $urandom_range(1, frame_px);
            // keep the total close to the item budget
            if (count > RANDOM_ITEMS - random_items)
                count = RANDOM_ITEMS - random_items;
            repeat (count) offer_pixel(rand_pixel());
            random_items += count;
        end

        settle();
        if (model.errors == 0 && model.pending() == 0)
            $display("box_filter_downsampler_tb: clean");
        else
            $display("box_filter_downsampler_tb: errors");
        $finish;
    end

endmodule

@@ box_filter_downsampler.f @@
hdl/bfd_pkg.sv
hdl/bfd_pix_if.sv
hdl/bfd_res_if.sv
hdl/bfd_cfg_if.sv
hdl/bfd_ram.sv
hdl/bfd_front.sv
hdl/bfd_fifo.sv
hdl/bfd_back.sv
hdl/box_filter_downsampler.sv
verif/box_filter_downsampler_tb.sv
